/* rtl/assert_macros.svh */
// Assertion macros used by the framer RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lls_pkg.sv */
// Shared types, constants and the CRC-8 update function of the framer.
`default_nettype none

package lls_pkg;

    localparam logic [7:0] LLS_REQ_PREFIX = 8'h31;
    localparam logic [7:0] LLS_RSP_PREFIX = 8'h3E;
    localparam logic [7:0] LLS_CRC_POLY   = 8'h8C;

    // Longest reply frame accepted, in bytes
    localparam int unsigned LLS_MAX_FRAME = 128;

    // Configuration register reset values
    localparam logic [7:0] LLS_SLAVE_ID_RST    = 8'd1;
    localparam logic [7:0] LLS_COMMAND_RST     = 8'd6;
    localparam logic [6:0] LLS_DATA_OFFSET_RST = 7'd0;
    localparam logic [2:0] LLS_DATA_WIDTH_RST  = 3'd2;
    localparam logic [2:0] LLS_DATA_WIDTH_MAX  = 3'd4;

    localparam int unsigned LLS_CFG_IDX_W = 2;

    typedef enum logic [LLS_CFG_IDX_W-1:0] {
        CFG_SLAVE_ID,
        CFG_COMMAND,
        CFG_DATA_OFFSET,
        CFG_DATA_WIDTH
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK,
        ST_PREFIX,
        ST_ADDRESS,
        ST_COMMAND,
        ST_CRC,
        ST_LENGTH
    } t_status;

    typedef enum logic {
        KIND_REQ,
        KIND_VERDICT
    } t_kind;

    // Position within the four-byte request frame
    typedef enum logic [1:0] {
        BEAT_PREFIX,
        BEAT_SLAVE,
        BEAT_CMD,
        BEAT_CRC
    } t_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
    } t_verdict;

    // Reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ LLS_CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

    // CRC after the request prefix alone, fixed at elaboration
    localparam logic [7:0] LLS_REQ_PREFIX_CRC = crc8_update(8'h00, LLS_REQ_PREFIX);

endpackage

`default_nettype wire

/* rtl/lls_in_if.sv */
// Input request channel: operation, received byte and end-of-reply flag.
`default_nettype none

interface lls_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, operation, rx_byte, rx_last, input ready);
    modport sink   (input valid, operation, rx_byte, rx_last, output ready);
endinterface

`default_nettype wire

/* rtl/lls_out_if.sv */
// Output result channel: request bytes to transmit and reply verdicts.
`default_nettype none

interface lls_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic [2:0]  status;
    logic [31:0] value;

    modport source (output valid, result_kind, tx_byte, last_of_run, status, value,
                    input ready);
    modport sink   (input valid, result_kind, tx_byte, last_of_run, status, value,
                    output ready);
endinterface

`default_nettype wire

/* rtl/lls_request_response_framer.sv */
// LLS request/response framer, master side: request framing and reply checking.
// Usage:
//   i_in carries requests: operation 0 asks for a request frame, operation 1
//   hands over one reply byte (rx_byte), with rx_last set on the final byte.
//   o_out carries results: a request gives four transmit bytes (prefix 0x31,
//   slave id, command, CRC-8), the last one flagged; a final reply byte gives
//   one verdict with status and the gathered little-endian value.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle.
// Timing:
//   A request is held in the input register, then its result is loaded into the
//   output register, which drives o_out. Reply bytes are taken one per cycle
//   unless a final byte waits behind an undelivered result; a request occupies
//   the output register until its four transmit bytes are delivered, one per
//   cycle while o_out is ready, and the next request waits in the input register.
// Reset (synchronous, active low) restores the register defaults, clears the
//   receive state and empties both registers.
// A stalled receiver holds the current result; reply bytes without a result
//   still pass, and the input stalls only behind an undelivered result.
`default_nettype none
`include "assert_macros.svh"

module lls_request_response_framer #(
    parameter int unsigned MAX_FRAME = lls_pkg::LLS_MAX_FRAME
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lls_in_if.sink                            i_in,
    lls_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [lls_pkg::LLS_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                        i_cfg_data
);
    import lls_pkg::*;

    // Configuration registers
    logic [7:0] r_slave_id;
    logic [7:0] r_command;
    logic [6:0] r_data_offset;
    logic [2:0] r_data_width;

    // Input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register
    logic        r_out_valid;
    t_kind       r_out_kind;
    t_beat       r_out_beat;
    t_verdict    r_out_verdict;
    logic [7:0]  r_tx_slave;
    logic [7:0]  r_tx_cmd;
    logic [7:0]  r_tx_crc;

    logic        w_in_has_result;
    logic        w_out_last_beat;
    logic        w_out_done;
    logic        w_out_free;
    logic        w_advance;
    logic        w_accept;
    logic [7:0]  w_req_crc;
    t_verdict    w_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id    <= LLS_SLAVE_ID_RST;
            r_command     <= LLS_COMMAND_RST;
            r_data_offset <= LLS_DATA_OFFSET_RST;
            r_data_width  <= LLS_DATA_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLAVE_ID:    r_slave_id    <= i_cfg_data;
                CFG_COMMAND:     r_command     <= i_cfg_data;
                CFG_DATA_OFFSET: r_data_offset <= i_cfg_data[6:0];
                CFG_DATA_WIDTH:  r_data_width  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Flow control between input and output registers
    always_comb begin
        w_in_has_result = !r_in_op || r_in_last;
        w_out_last_beat = (r_out_kind == KIND_VERDICT) || (r_out_beat == BEAT_CRC);
        w_out_done      = r_out_valid && o_out.ready && w_out_last_beat;
        w_out_free      = !r_out_valid || w_out_done;
        w_advance       = r_in_valid && (!w_in_has_result || w_out_free);
        i_in.ready      = !r_in_valid || w_advance;
        w_accept        = i_in.valid && i_in.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.rx_byte;
            r_in_last <= i_in.rx_last;
        end
    end

    lls_rx_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_rx_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance && r_in_op),
        .i_clear       (w_advance && !r_in_op),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_slave_id    (r_slave_id),
        .i_command     (r_command),
        .i_data_offset (r_data_offset),
        .i_data_width  (r_data_width),
        .o_verdict     (w_verdict)
    );

    // Request CRC: prefix part is a constant
    assign w_req_crc = crc8_update(crc8_update(LLS_REQ_PREFIX_CRC, r_slave_id), r_command);

    // Output register: load a new result or step through request bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_kind  <= KIND_REQ;
            r_out_beat  <= BEAT_PREFIX;
        end else if (w_advance && w_in_has_result) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= r_in_op ? KIND_VERDICT : KIND_REQ;
            r_out_beat  <= BEAT_PREFIX;
        end else if (r_out_valid && o_out.ready) begin
            if (w_out_last_beat) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_beat <= t_beat'(r_out_beat + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_in_has_result) begin
            r_tx_slave <= r_slave_id;
            r_tx_cmd   <= r_command;
            r_tx_crc   <= w_req_crc;
            if (r_in_op) begin
                r_out_verdict <= w_verdict;
            end else begin
                r_out_verdict <= '{status: ST_OK, value: 32'd0};
            end
        end
    end

    // Result fields
    always_comb begin
        o_out.valid       = r_out_valid;
        o_out.result_kind = r_out_kind;
        o_out.last_of_run = w_out_last_beat;
        o_out.status      = r_out_verdict.status;
        o_out.value       = r_out_verdict.value;
        o_out.tx_byte     = 8'd0;
        if (r_out_kind == KIND_REQ) begin
            unique case (r_out_beat)
                BEAT_PREFIX: o_out.tx_byte = LLS_REQ_PREFIX;
                BEAT_SLAVE:  o_out.tx_byte = r_tx_slave;
                BEAT_CMD:    o_out.tx_byte = r_tx_cmd;
                BEAT_CRC:    o_out.tx_byte = r_tx_crc;
                default:     o_out.tx_byte = 8'd0;
            endcase
        end
    end

    `LLS_ASSERT_IMPL(a_stall_needs_full, i_clk, i_rst_n, !i_in.ready,
        r_in_valid && r_out_valid, "input stalled without a pending result")
    `LLS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n,
        w_advance && w_in_has_result && r_out_valid,
        o_out.ready && w_out_last_beat, "result overwritten before delivery")
    `LLS_ASSERT_NEXT(a_req_continues, i_clk, i_rst_n,
        o_out.valid && o_out.ready && r_out_kind == KIND_REQ && r_out_beat != BEAT_CRC,
        o_out.valid && r_out_kind == KIND_REQ, "request frame cut short")

endmodule

`default_nettype wire

/* rtl/lls_rx_parse.sv */
// Reply parser: byte index, running CRC, header checks, data gathering, verdict.
`default_nettype none

module lls_rx_parse #(
    parameter int unsigned MAX_FRAME = lls_pkg::LLS_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_clear,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [7:0]        i_slave_id,
    input  logic [7:0]        i_command,
    input  logic [6:0]        i_data_offset,
    input  logic [2:0]        i_data_width,
    output lls_pkg::t_verdict o_verdict
);
    import lls_pkg::*;

    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);

    logic [7:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_crc,        n_crc;
    t_status     r_first_err,  n_first_err;
    logic [31:0] r_gathered,   n_gathered;

    logic [2:0]  w_eff_width;
    logic [7:0]  w_start;
    logic [8:0]  w_len;
    logic [8:0]  w_need;
    logic [8:0]  w_rel;
    logic [8:0]  w_end;
    logic        w_in_window;
    logic [4:0]  w_shift;
    t_status     w_status;

    // Window geometry; widths above four act as four
    always_comb begin
        w_eff_width = (i_data_width > LLS_DATA_WIDTH_MAX) ? LLS_DATA_WIDTH_MAX : i_data_width;
        w_start     = 8'd3 + {1'b0, i_data_offset};
        w_len       = {1'b0, r_byte_index} + 9'd1;
        w_need      = {1'b0, w_start} + {6'b0, w_eff_width} + 9'd1;
        w_end       = {1'b0, w_start} + {6'b0, w_eff_width};
        w_rel       = {1'b0, r_byte_index} - {1'b0, w_start};
        w_in_window = (r_byte_index >= w_start) && ({1'b0, r_byte_index} < w_end);
        w_shift     = {w_rel[1:0], 3'b000};
    end

    // First header error, in byte order
    always_comb begin
        n_first_err = r_first_err;
        if (r_first_err == ST_OK) begin
            if (r_byte_index == 8'd0 && i_byte != LLS_RSP_PREFIX) begin
                n_first_err = ST_PREFIX;
            end else if (r_byte_index == 8'd1 && i_byte != i_slave_id) begin
                n_first_err = ST_ADDRESS;
            end else if (r_byte_index == 8'd2 && i_byte != i_command) begin
                n_first_err = ST_COMMAND;
            end
        end
    end

    // Verdict for a final byte: header, then CRC, then length
    always_comb begin
        priority if (n_first_err != ST_OK) begin
            w_status = n_first_err;
        end else if (i_byte != r_crc) begin
            w_status = ST_CRC;
        end else if (w_len < w_need || w_len > MAX_LEN) begin
            w_status = ST_LENGTH;
        end else begin
            w_status = ST_OK;
        end
        o_verdict.status = w_status;
        o_verdict.value  = (w_status == ST_OK) ? r_gathered : 32'd0;
    end

    // Next receive state
    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_gathered   = r_gathered;
        if (i_clear || (i_step && i_last)) begin
            n_byte_index = 8'd0;
            n_crc        = 8'd0;
            n_gathered   = 32'd0;
        end else if (i_step) begin
            n_crc = crc8_update(r_crc, i_byte);
            if (r_byte_index != 8'hFF) begin
                n_byte_index = r_byte_index + 8'd1;
            end
            if (w_in_window) begin
                n_gathered = r_gathered | ({24'd0, i_byte} << w_shift);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 8'd0;
            r_crc        <= 8'd0;
            r_first_err  <= ST_OK;
            r_gathered   <= 32'd0;
        end else begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_gathered   <= n_gathered;
            if (i_clear || (i_step && i_last)) begin
                r_first_err <= ST_OK;
            end else if (i_step) begin
                r_first_err <= n_first_err;
            end
        end
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the LLS framer: random requests and reply frames against a predictor.
module testbench;
    import lls_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RX_BYTE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_request;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        t_status     status;
        logic [31:0] value;
    } t_result;

    typedef enum int {
        REPLY_GOOD,
        REPLY_BAD_HEADER,
        REPLY_BAD_CRC,
        REPLY_SHORT,
        REPLY_LONG,
        REPLY_ABORTED
    } t_reply_mode;

    typedef logic [7:0] t_byte_q[$];

    logic     i_clk;
    logic     i_rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    logic [7:0] cfg_data;

    lls_in_if  u_in_if ();
    lls_out_if u_out_if ();

    lls_request_response_framer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (u_in_if),
        .o_out      (u_out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor copy of the registers
    logic [7:0] exp_slave;
    logic [7:0] exp_cmd;
    logic [6:0] exp_offset;
    logic [2:0] exp_width;

    // Predictor copy of the reply receive state
    logic [7:0]  rx_count;
    logic [7:0]  rx_crc;
    t_status     rx_error;
    logic [31:0] rx_value;

    t_request request_q[$];
    t_result  awaited_q[$];
    t_request cur_request;
    bit       in_busy;
    int       in_idle_pct;
    int       out_idle_pct;
    int       stim_count;
    int       mismatches;
    int       stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Reflected CRC-8, polynomial 0x8C, one byte
    function automatic logic [7:0] crc8_reflected(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ LLS_CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    task automatic clear_rx_state();
        rx_count = '0;
        rx_crc   = '0;
        rx_error = ST_OK;
        rx_value = '0;
    endtask

    task automatic expect_result(input t_kind kind, input logic [7:0] tx, input logic last,
                                 input t_status status, input logic [31:0] value);
        t_result res;
        res.kind    = kind;
        res.tx_byte = tx;
        res.last    = last;
        res.status  = status;
        res.value   = value;
        awaited_q.push_back(res);
    endtask

    // Expected results of one accepted request, updating the receive state
    task automatic predict_framer(input t_request req);
        logic [7:0]  crc;
        int unsigned eff_w;
        int unsigned start;
        int unsigned frame_len;
        t_status     verdict;
        if (req.op == OP_REQUEST) begin
            crc = crc8_reflected(crc8_reflected(crc8_reflected(8'h00, LLS_REQ_PREFIX),
                                                exp_slave), exp_cmd);
            clear_rx_state();
            expect_result(KIND_REQ, LLS_REQ_PREFIX, 1'b0, ST_OK, 32'h0);
            expect_result(KIND_REQ, exp_slave, 1'b0, ST_OK, 32'h0);
            expect_result(KIND_REQ, exp_cmd, 1'b0, ST_OK, 32'h0);
            expect_result(KIND_REQ, crc, 1'b1, ST_OK, 32'h0);
        end else begin
            eff_w = (exp_width > 3'd4) ? 4 : exp_width;
            start = 3 + exp_offset;
            // Header checks keep only the first error
            if (rx_error == ST_OK) begin
                if (rx_count == 0 && req.rx_byte != LLS_RSP_PREFIX) begin
                    rx_error = ST_PREFIX;
                end else if (rx_count == 1 && req.rx_byte != exp_slave) begin
                    rx_error = ST_ADDRESS;
                end else if (rx_count == 2 && req.rx_byte != exp_cmd) begin
                    rx_error = ST_COMMAND;
                end
            end
            if (req.rx_last) begin
                frame_len = rx_count + 1;
                if (rx_error != ST_OK) begin
                    verdict = rx_error;
                end else if (req.rx_byte != rx_crc) begin
                    verdict = ST_CRC;
                end else if (frame_len < start + eff_w + 1 || frame_len > LLS_MAX_FRAME) begin
                    verdict = ST_LENGTH;
                end else begin
                    verdict = ST_OK;
                end
                expect_result(KIND_VERDICT, 8'h00, 1'b1, verdict,
                              (verdict == ST_OK) ? rx_value : 32'h0);
                clear_rx_state();
            end else begin
                if (rx_count >= start && rx_count < start + eff_w) begin
                    rx_value |= 32'(req.rx_byte) << (8 * (rx_count - start));
                end
                rx_crc = crc8_reflected(rx_crc, req.rx_byte);
                if (rx_count != 8'hFF) begin
                    rx_count++;
                end
            end
        end
    endtask

    // Compare one delivered result with the oldest awaited one
    task automatic check_result();
        t_result want;
        if (awaited_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected result: kind %0d tx %02h last %0d status %0d value %08h",
                         u_out_if.result_kind, u_out_if.tx_byte, u_out_if.last_of_run,
                         u_out_if.status, u_out_if.value);
            end
        end else begin
            want = awaited_q.pop_front();
            if (want.kind !== u_out_if.result_kind || want.tx_byte !== u_out_if.tx_byte ||
                want.last !== u_out_if.last_of_run || want.status !== u_out_if.status ||
                want.value !== u_out_if.value) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result mismatch (exp/got): kind %0d/%0d tx %02h/%02h last %0d/%0d",
                             want.kind, u_out_if.result_kind, want.tx_byte, u_out_if.tx_byte,
                             want.last, u_out_if.last_of_run);
                    $display("    status %0d/%0d value %08h/%08h", want.status,
                             u_out_if.status, want.value, u_out_if.value);
                end
            end
        end
    endtask

    // Request driver and ready toggling, on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else if (!in_busy) begin
            if (request_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                cur_request = request_q.pop_front();
                in_busy = 1'b1;
                u_in_if.valid     <= 1'b1;
                u_in_if.operation <= cur_request.op;
                u_in_if.rx_byte   <= cur_request.rx_byte;
                u_in_if.rx_last   <= cur_request.rx_last;
            end else begin
                u_in_if.valid <= 1'b0;
            end
        end
        u_out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Handshake monitor, on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (u_in_if.valid && u_in_if.ready) begin
                predict_framer(cur_request);
                in_busy = 1'b0;
            end
            if (u_out_if.valid && u_out_if.ready) begin
                check_result();
            end
            if ((u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Watchdog: no handshake for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_item(input logic op, input logic [7:0] rx_byte, input logic rx_last);
        t_request req;
        req.op      = op;
        req.rx_byte = rx_byte;
        req.rx_last = rx_last;
        request_q.push_back(req);
        stim_count++;
    endtask

    // Frame bytes, then the CRC (optionally corrupted) as the final byte
    task automatic push_frame(input t_byte_q frame, input logic [7:0] crc_flip);
        logic [7:0] crc;
        crc = 8'h00;
        foreach (frame[k]) begin
            push_item(OP_RX_BYTE, frame[k], 1'b0);
            crc = crc8_reflected(crc, frame[k]);
        end
        push_item(OP_RX_BYTE, crc ^ crc_flip, 1'b1);
    endtask

    task automatic queue_reply(input t_reply_mode mode, input int unsigned extra);
        t_byte_q     frame;
        int unsigned body;
        int unsigned keep;
        int unsigned pos;
        body = exp_offset + ((exp_width > 3'd4) ? 4 : exp_width);
        if (mode == REPLY_LONG) begin
            body += (extra != 0) ? extra : $urandom_range(3, 1);
        end
        frame = {LLS_RSP_PREFIX, exp_slave, exp_cmd};
        repeat (body) frame.push_back(8'($urandom_range(255)));
        case (mode)
            REPLY_BAD_HEADER: begin
                pos = $urandom_range(2);
                frame[pos] = frame[pos] ^ 8'($urandom_range(255, 1));
                push_frame(frame, 8'h00);
            end
            REPLY_BAD_CRC: begin
                push_frame(frame, 8'($urandom_range(255, 1)));
            end
            REPLY_SHORT: begin
                keep = $urandom_range(2 + body, 1);
                while (frame.size() > keep) void'(frame.pop_back());
                push_frame(frame, 8'h00);
            end
            REPLY_ABORTED: begin
                // Partial reply cut off by a new request frame
                keep = $urandom_range(frame.size(), 1);
                for (int k = 0; k < keep; k++) begin
                    push_item(OP_RX_BYTE, frame[k], 1'b0);
                end
                push_item(OP_REQUEST, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            default: begin
                push_frame(frame, 8'h00);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || in_busy || awaited_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SLAVE_ID:    exp_slave  = data;
            CFG_COMMAND:     exp_cmd    = data;
            CFG_DATA_OFFSET: exp_offset = data[6:0];
            CFG_DATA_WIDTH:  exp_width  = data[2:0];
        endcase
    endtask

    // Reset-value checks: field extremes and each reply error
    task automatic queue_directed();
        t_byte_q frame;
        push_item(OP_REQUEST, 8'hFF, 1'b1);
        frame = {LLS_RSP_PREFIX, exp_slave, exp_cmd, 8'hFF, 8'h00};
        push_frame(frame, 8'h00);
        // single wrong prefix byte
        push_item(OP_RX_BYTE, 8'h00, 1'b1);
        // wrong address on the final byte
        push_item(OP_RX_BYTE, LLS_RSP_PREFIX, 1'b0);
        push_item(OP_RX_BYTE, exp_slave ^ 8'h80, 1'b1);
        // wrong command on the final byte
        push_item(OP_RX_BYTE, LLS_RSP_PREFIX, 1'b0);
        push_item(OP_RX_BYTE, exp_slave, 1'b0);
        push_item(OP_RX_BYTE, exp_cmd ^ 8'h01, 1'b1);
        // header only, valid CRC: too short
        frame = {LLS_RSP_PREFIX, exp_slave, exp_cmd};
        push_frame(frame, 8'h00);
        // reply abandoned by a request
        push_item(OP_RX_BYTE, LLS_RSP_PREFIX, 1'b0);
        push_item(OP_RX_BYTE, exp_slave, 1'b0);
        push_item(OP_REQUEST, 8'h00, 1'b0);
        frame = {LLS_RSP_PREFIX, exp_slave, exp_cmd, 8'h5A, 8'hA5};
        push_frame(frame, 8'hFF);
    endtask

    // One register setting followed by a mix of random traffic
    task automatic run_phase(input logic [7:0] slave, input logic [7:0] cmd,
                             input logic [6:0] offset, input logic [2:0] width,
                             input int idle_pct, input int budget, input bit huge_frame);
        int first;
        int roll;
        wait_drained();
        write_reg(CFG_SLAVE_ID, slave);
        write_reg(CFG_COMMAND, cmd);
        write_reg(CFG_DATA_OFFSET, {1'($urandom_range(1)), offset});
        write_reg(CFG_DATA_WIDTH, {5'($urandom_range(31)), width});
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        in_idle_pct  = idle_pct;
        out_idle_pct = idle_pct;
        first = stim_count;
        if (huge_frame) begin
            // well past 255 bytes: the byte count saturates
            queue_reply(REPLY_LONG, 130);
        end
        while (stim_count - first < budget) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                push_item(OP_REQUEST, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (roll < 60) begin
                queue_reply(REPLY_GOOD, 0);
            end else if (roll < 68) begin
                queue_reply(REPLY_BAD_HEADER, 0);
            end else if (roll < 76) begin
                queue_reply(REPLY_BAD_CRC, 0);
            end else if (roll < 83) begin
                queue_reply(REPLY_SHORT, 0);
            end else if (roll < 89) begin
                queue_reply(REPLY_LONG, 0);
            end else if (roll < 94) begin
                queue_reply(REPLY_ABORTED, 0);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    push_item(OP_RX_BYTE, 8'($urandom_range(255)), $urandom_range(99) < 30);
                end
            end
        end
        // close with a request so no reply is left open
        push_item(OP_REQUEST, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_SLAVE_ID;
        cfg_data = 8'h00;
        u_in_if.valid     = 1'b0;
        u_in_if.operation = OP_REQUEST;
        u_in_if.rx_byte   = 8'h00;
        u_in_if.rx_last   = 1'b0;
        u_out_if.ready    = 1'b0;
        in_busy      = 1'b0;
        in_idle_pct  = 12;
        out_idle_pct = 12;
        stim_count   = 0;
        mismatches   = 0;
        stall_cycles = 0;
        exp_slave  = LLS_SLAVE_ID_RST;
        exp_cmd    = LLS_COMMAND_RST;
        exp_offset = LLS_DATA_OFFSET_RST;
        exp_width  = LLS_DATA_WIDTH_RST;
        clear_rx_state();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        // no idling on either side through the first random phase
        run_phase(8'hFF, 8'h00, 7'd0, 3'd4, 0, 30, 1'b0);
        run_phase(8'h00, 8'hFF, 7'd127, 3'd1, 12, 0, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 7'd3, 3'd0, 12, 12, 1'b0);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 7'd2, 3'd7, 12, 12, 1'b0);
        run_phase(LLS_RSP_PREFIX, LLS_REQ_PREFIX, 7'd1, 3'd3, 12, 12, 1'b0);
        run_phase(LLS_SLAVE_ID_RST, LLS_COMMAND_RST, 7'd0, 3'd2, 12, 10, 1'b0);
        wait_drained();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* lls_request_response_framer.f */
+incdir+rtl
rtl/lls_pkg.sv
rtl/lls_in_if.sv
rtl/lls_out_if.sv
rtl/lls_rx_parse.sv
rtl/lls_request_response_framer.sv
tb/sv/testbench.sv
